FILE: sv/lav_pkg.sv
// Shared types and constants for the look-at view matrix pipeline.
// Used by lav_norm, lav_cross, lav_rows and look_at_view_matrix; depends on nothing.
package lav_pkg;

   // Pipeline depths of the normalising unit
   localparam int NSH   = 6;   // binary-search shift stages, 32 down to 1
   localparam int NSQRT = 31;  // one root bit per stage
   localparam int NDIV  = 31;  // one quotient bit per stage

   // Row codes and output constants
   localparam logic [1:0]         ROW_LAST = 2'd3;
   localparam logic signed [35:0] ONE_OUT  = 36'sd65536;

   // Three-component vector, 32-bit signed (Q16.16 positions or Q1.30 axes)
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   // Wide vector fed to a normaliser (differences and cross products)
   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } wvec_type;

   // Data that rides alongside a vector through the pipeline
   typedef struct packed {
      vec_type eye;
      vec_type aux_a;
      vec_type aux_b;
      logic    degen;
   } side_type;

endpackage

FILE: sv/lav_norm.sv
// Pipelined vector normaliser: range shift, sum of squares, square root and division.
// Depends on lav_pkg; one vector may enter every cycle.
module lav_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lav_pkg::wvec_type  in_vec,
   input  lav_pkg::side_type  in_side,
   output logic               out_valid,
   output lav_pkg::vec_type   out_unit,
   output logic               out_zero,
   output lav_pkg::side_type  out_side
);

   localparam int NSH   = lav_pkg::NSH;
   localparam int NSQRT = lav_pkg::NSQRT;
   localparam int NDIV  = lav_pkg::NDIV;

   logic signed [63:0] in_c [3];
   assign in_c[0] = in_vec.x;
   assign in_c[1] = in_vec.y;
   assign in_c[2] = in_vec.z;

   // Split each component into sign and magnitude
   logic               a_valid_ff;
   logic [63:0]        a_mag_ff [3];
   logic [2:0]         a_neg_ff;
   lav_pkg::side_type  a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_neg_ff[i] <= in_c[i][63];
         a_mag_ff[i] <= in_c[i][63] ? 64'(-in_c[i]) : 64'(in_c[i]);
      end
      a_side_ff <= in_side;
   end

   // Pick the largest magnitude
   logic [63:0] max01;
   logic [63:0] max_all;
   always_comb begin
      max01   = (a_mag_ff[0] > a_mag_ff[1]) ? a_mag_ff[0] : a_mag_ff[1];
      max_all = (a_mag_ff[2] > max01) ? a_mag_ff[2] : max01;
   end

   logic               sh_valid_ff [0:NSH];
   logic [63:0]        sh_mx_ff    [0:NSH];
   logic [63:0]        sh_mag_ff   [0:NSH][3];
   logic [2:0]         sh_neg_ff   [0:NSH];
   logic               sh_zero_ff  [0:NSH];
   lav_pkg::side_type  sh_side_ff  [0:NSH];

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_valid_ff[0] <= 1'b0;
      end else begin
         sh_valid_ff[0] <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sh_mx_ff[0]   <= max_all;
      for (int i = 0; i < 3; i++) begin
         sh_mag_ff[0][i] <= a_mag_ff[i];
      end
      sh_neg_ff[0]  <= a_neg_ff;
      sh_zero_ff[0] <= ~|(a_mag_ff[0] | a_mag_ff[1] | a_mag_ff[2]);
      sh_side_ff[0] <= a_side_ff;
   end

   // Left-align the largest magnitude at bit 63, halving the step each stage
   for (genvar k = 1; k <= NSH; k++) begin : g_shift
      localparam int SH = 64 >> k;

      always_ff @(posedge clock) begin
         if (reset) begin
            sh_valid_ff[k] <= 1'b0;
         end else begin
            sh_valid_ff[k] <= sh_valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (sh_mx_ff[k-1][63 -: SH] == '0) begin
            sh_mx_ff[k] <= sh_mx_ff[k-1] << SH;
            for (int i = 0; i < 3; i++) begin
               sh_mag_ff[k][i] <= sh_mag_ff[k-1][i] << SH;
            end
         end else begin
            sh_mx_ff[k] <= sh_mx_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               sh_mag_ff[k][i] <= sh_mag_ff[k-1][i];
            end
         end
         sh_neg_ff[k]  <= sh_neg_ff[k-1];
         sh_zero_ff[k] <= sh_zero_ff[k-1];
         sh_side_ff[k] <= sh_side_ff[k-1];
      end
   end

   // Square the 30-bit scaled magnitudes (largest now in [2^29, 2^30))
   logic [29:0] m30 [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         m30[i] = sh_mag_ff[NSH][i][63:34];
      end
   end

   logic               sq_valid_ff;
   logic [59:0]        sq_ff   [3];
   logic [29:0]        sq_m_ff [3];
   logic [2:0]         sq_neg_ff;
   logic               sq_zero_ff;
   lav_pkg::side_type  sq_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= sh_valid_ff[NSH];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i]   <= 60'(m30[i]) * 60'(m30[i]);
         sq_m_ff[i] <= m30[i];
      end
      sq_neg_ff  <= sh_neg_ff[NSH];
      sq_zero_ff <= sh_zero_ff[NSH];
      sq_side_ff <= sh_side_ff[NSH];
   end

   // Square root, one result bit per stage; entry 0 holds the sum of squares
   logic               rt_valid_ff [0:NSQRT];
   logic [61:0]        rt_n_ff     [0:NSQRT];
   logic [33:0]        rt_rem_ff   [0:NSQRT];
   logic [30:0]        rt_root_ff  [0:NSQRT];
   logic [29:0]        rt_m_ff     [0:NSQRT][3];
   logic [2:0]         rt_neg_ff   [0:NSQRT];
   logic               rt_zero_ff  [0:NSQRT];
   lav_pkg::side_type  rt_side_ff  [0:NSQRT];

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff[0] <= 1'b0;
      end else begin
         rt_valid_ff[0] <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rt_n_ff[0]    <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      rt_rem_ff[0]  <= '0;
      rt_root_ff[0] <= '0;
      for (int i = 0; i < 3; i++) begin
         rt_m_ff[0][i] <= sq_m_ff[i];
      end
      rt_neg_ff[0]  <= sq_neg_ff;
      rt_zero_ff[0] <= sq_zero_ff;
      rt_side_ff[0] <= sq_side_ff;
   end

   for (genvar j = 1; j <= NSQRT; j++) begin : g_sqrt
      logic [33:0] rem2;
      logic [33:0] trial;
      assign rem2  = {rt_rem_ff[j-1][31:0], rt_n_ff[j-1][61:60]};
      assign trial = {1'b0, rt_root_ff[j-1], 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[j] <= 1'b0;
         end else begin
            rt_valid_ff[j] <= rt_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rem2 >= trial) begin
            rt_rem_ff[j]  <= rem2 - trial;
            rt_root_ff[j] <= {rt_root_ff[j-1][29:0], 1'b1};
         end else begin
            rt_rem_ff[j]  <= rem2;
            rt_root_ff[j] <= {rt_root_ff[j-1][29:0], 1'b0};
         end
         rt_n_ff[j] <= rt_n_ff[j-1] << 2;
         for (int i = 0; i < 3; i++) begin
            rt_m_ff[j][i] <= rt_m_ff[j-1][i];
         end
         rt_neg_ff[j]  <= rt_neg_ff[j-1];
         rt_zero_ff[j] <= rt_zero_ff[j-1];
         rt_side_ff[j] <= rt_side_ff[j-1];
      end
   end

   // Form the rounded numerator m * 2^30 + len / 2 and preload the top bits
   logic [60:0] num [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = {1'b0, rt_m_ff[NSQRT][i], 30'b0} + {31'b0, rt_root_ff[NSQRT][30:1]};
      end
   end

   logic               dv_valid_ff [0:NDIV];
   logic [30:0]        dv_len_ff   [0:NDIV];
   logic [30:0]        dv_rem_ff   [0:NDIV][3];
   logic [30:0]        dv_low_ff   [0:NDIV][3];
   logic [30:0]        dv_q_ff     [0:NDIV][3];
   logic [2:0]         dv_neg_ff   [0:NDIV];
   logic               dv_zero_ff  [0:NDIV];
   lav_pkg::side_type  dv_side_ff  [0:NDIV];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else begin
         dv_valid_ff[0] <= rt_valid_ff[NSQRT];
      end
   end

   always_ff @(posedge clock) begin
      dv_len_ff[0] <= rt_root_ff[NSQRT];
      for (int i = 0; i < 3; i++) begin
         dv_rem_ff[0][i] <= {1'b0, num[i][60:31]};
         dv_low_ff[0][i] <= num[i][30:0];
         dv_q_ff[0][i]   <= '0;
      end
      dv_neg_ff[0]  <= rt_neg_ff[NSQRT];
      dv_zero_ff[0] <= rt_zero_ff[NSQRT];
      dv_side_ff[0] <= rt_side_ff[NSQRT];
   end

   // Restoring division, one quotient bit per stage for all three lanes
   for (genvar j = 1; j <= NDIV; j++) begin : g_div
      logic [31:0] r2 [3];
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            r2[i] = {dv_rem_ff[j-1][i], dv_low_ff[j-1][i][30]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (r2[i] >= {1'b0, dv_len_ff[j-1]}) begin
               dv_rem_ff[j][i] <= 31'(r2[i] - {1'b0, dv_len_ff[j-1]});
               dv_q_ff[j][i]   <= {dv_q_ff[j-1][i][29:0], 1'b1};
            end else begin
               dv_rem_ff[j][i] <= r2[i][30:0];
               dv_q_ff[j][i]   <= {dv_q_ff[j-1][i][29:0], 1'b0};
            end
            dv_low_ff[j][i] <= dv_low_ff[j-1][i] << 1;
         end
         dv_len_ff[j]  <= dv_len_ff[j-1];
         dv_neg_ff[j]  <= dv_neg_ff[j-1];
         dv_zero_ff[j] <= dv_zero_ff[j-1];
         dv_side_ff[j] <= dv_side_ff[j-1];
      end
   end

   // Restore signs; drop to zero for a zero-length vector
   logic [31:0] unit_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_zero_ff[NDIV]) begin
            unit_in[i] = '0;
         end else if (dv_neg_ff[NDIV][i]) begin
            unit_in[i] = -{1'b0, dv_q_ff[NDIV][i]};
         end else begin
            unit_in[i] = {1'b0, dv_q_ff[NDIV][i]};
         end
      end
   end

   logic               out_valid_ff;
   lav_pkg::vec_type   out_unit_ff;
   logic               out_zero_ff;
   lav_pkg::side_type  out_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid_ff[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      out_unit_ff.x <= unit_in[0];
      out_unit_ff.y <= unit_in[1];
      out_unit_ff.z <= unit_in[2];
      out_zero_ff   <= dv_zero_ff[NDIV];
      out_side_ff   <= dv_side_ff[NDIV];
   end

   assign out_valid = out_valid_ff;
   assign out_unit  = out_unit_ff;
   assign out_zero  = out_zero_ff;
   assign out_side  = out_side_ff;

endmodule

FILE: sv/lav_cross.sv
// Two-stage cross product a x b of 32-bit signed vectors into a 64-bit vector.
// Depends on lav_pkg for the vector and sideband types.
module lav_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  lav_pkg::vec_type   in_a,
   input  lav_pkg::vec_type   in_b,
   input  lav_pkg::side_type  in_side,
   output logic               out_valid,
   output lav_pkg::wvec_type  out_vec,
   output lav_pkg::side_type  out_side
);

   // Form the six partial products
   logic               p_valid_ff;
   logic signed [63:0] p_ff [6];
   lav_pkg::side_type  p_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      p_ff[0]   <= in_a.y * in_b.z;
      p_ff[1]   <= in_a.z * in_b.y;
      p_ff[2]   <= in_a.z * in_b.x;
      p_ff[3]   <= in_a.x * in_b.z;
      p_ff[4]   <= in_a.x * in_b.y;
      p_ff[5]   <= in_a.y * in_b.x;
      p_side_ff <= in_side;
   end

   // Take the differences
   logic               out_valid_ff;
   lav_pkg::wvec_type  out_vec_ff;
   lav_pkg::side_type  out_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_vec_ff.x <= p_ff[0] - p_ff[1];
      out_vec_ff.y <= p_ff[2] - p_ff[3];
      out_vec_ff.z <= p_ff[4] - p_ff[5];
      out_side_ff  <= p_side_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;
   assign out_side  = out_side_ff;

endmodule

FILE: sv/lav_rows.sv
// Translation dot products, output rounding and the four-row result sequencer.
// Depends on lav_pkg for vector types, row codes and the unit constant.
module lav_rows (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  lav_pkg::vec_type    in_eye,
   input  lav_pkg::vec_type    in_right,
   input  lav_pkg::vec_type    in_cup,
   input  lav_pkg::vec_type    in_dir,
   input  logic                in_degen,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_row_index,
   output logic signed [35:0]  rsp_col0,
   output logic signed [35:0]  rsp_col1,
   output logic signed [35:0]  rsp_col2,
   output logic signed [35:0]  rsp_col3,
   output logic                rsp_last_row,
   output logic                rsp_degenerate
);

   logic signed [31:0] ax   [3][3];
   logic signed [31:0] eyec [3];

   assign ax[0][0] = in_right.x;
   assign ax[0][1] = in_right.y;
   assign ax[0][2] = in_right.z;
   assign ax[1][0] = in_cup.x;
   assign ax[1][1] = in_cup.y;
   assign ax[1][2] = in_cup.z;
   assign ax[2][0] = in_dir.x;
   assign ax[2][1] = in_dir.y;
   assign ax[2][2] = in_dir.z;
   assign eyec[0]  = in_eye.x;
   assign eyec[1]  = in_eye.y;
   assign eyec[2]  = in_eye.z;

   // Multiply each axis component by the eye position
   logic               r1_valid_ff;
   logic signed [63:0] r1_p_ff  [3][3];
   logic signed [31:0] r1_ax_ff [3][3];
   logic               r1_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
      end else begin
         r1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r1_p_ff[r][c]  <= ax[r][c] * eyec[c];
            r1_ax_ff[r][c] <= ax[r][c];
         end
      end
      r1_degen_ff <= in_degen;
   end

   // Sum the dot products
   logic               r2_valid_ff;
   logic signed [63:0] r2_dot_ff [3];
   logic signed [31:0] r2_ax_ff  [3][3];
   logic               r2_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_valid_ff <= 1'b0;
      end else begin
         r2_valid_ff <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         r2_dot_ff[r] <= r1_p_ff[r][0] + r1_p_ff[r][1] + r1_p_ff[r][2];
         for (int c = 0; c < 3; c++) begin
            r2_ax_ff[r][c] <= r1_ax_ff[r][c];
         end
      end
      r2_degen_ff <= r1_degen_ff;
   end

   // Take magnitudes ahead of rounding
   logic               r3_valid_ff;
   logic [2:0]         r3_dneg_ff;
   logic [63:0]        r3_dmag_ff [3];
   logic               r3_aneg_ff [3][3];
   logic [31:0]        r3_amag_ff [3][3];
   logic               r3_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r3_valid_ff <= 1'b0;
      end else begin
         r3_valid_ff <= r2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         r3_dneg_ff[r] <= r2_dot_ff[r][63];
         r3_dmag_ff[r] <= r2_dot_ff[r][63] ? 64'(-r2_dot_ff[r]) : 64'(r2_dot_ff[r]);
         for (int c = 0; c < 3; c++) begin
            r3_aneg_ff[r][c] <= r2_ax_ff[r][c][31];
            r3_amag_ff[r][c] <= r2_ax_ff[r][c][31] ? 32'(-r2_ax_ff[r][c])
                                                   : 32'(r2_ax_ff[r][c]);
         end
      end
      r3_degen_ff <= r2_degen_ff;
   end

   // Round half away from zero: dot by 2^30, axis components by 2^14
   logic [63:0] dsum [3];
   logic [31:0] asum [3][3];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         dsum[r] = r3_dmag_ff[r] + 64'h0000_0000_2000_0000;
         for (int c = 0; c < 3; c++) begin
            asum[r][c] = r3_amag_ff[r][c] + 32'h0000_2000;
         end
      end
   end

   logic               r4_valid_ff;
   logic [2:0]         r4_dneg_ff;
   logic [33:0]        r4_drnd_ff [3];
   logic               r4_aneg_ff [3][3];
   logic [17:0]        r4_arnd_ff [3][3];
   logic               r4_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r4_valid_ff <= 1'b0;
      end else begin
         r4_valid_ff <= r3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         r4_drnd_ff[r] <= dsum[r][63:30];
         for (int c = 0; c < 3; c++) begin
            r4_arnd_ff[r][c] <= asum[r][c][31:14];
            r4_aneg_ff[r][c] <= r3_aneg_ff[r][c];
         end
      end
      r4_dneg_ff  <= r3_dneg_ff;
      r4_degen_ff <= r3_degen_ff;
   end

   // Apply signs into the row buffer; hold it while the rows go out
   logic               r5_valid_ff;
   logic signed [35:0] r5_col_ff [3][3];
   logic signed [35:0] r5_tr_ff  [3];
   logic               r5_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r5_valid_ff <= 1'b0;
      end else begin
         r5_valid_ff <= r4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r4_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            r5_tr_ff[r] <= r4_dneg_ff[r] ? 36'(r4_drnd_ff[r]) : -36'(r4_drnd_ff[r]);
            for (int c = 0; c < 3; c++) begin
               r5_col_ff[r][c] <= r4_aneg_ff[r][c] ? -36'(r4_arnd_ff[r][c])
                                                   : 36'(r4_arnd_ff[r][c]);
            end
         end
         r5_degen_ff <= r4_degen_ff;
      end
   end

   // Sequence rows 0 to 3 on consecutive cycles
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       emit_in;
   logic [1:0] row_sel;

   always_comb begin
      emit_in = r5_valid_ff || (cnt_ff != 2'd0);
      row_sel = r5_valid_ff ? 2'd0 : cnt_ff;
      if (r5_valid_ff) begin
         cnt_in = 2'd1;
      end else if (cnt_ff != 2'd0) begin
         cnt_in = cnt_ff + 2'd1;
      end else begin
         cnt_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   logic               strobe_ff;
   logic [1:0]         row_index_ff;
   logic signed [35:0] col0_ff;
   logic signed [35:0] col1_ff;
   logic signed [35:0] col2_ff;
   logic signed [35:0] col3_ff;
   logic               last_row_ff;
   logic               degenerate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      row_index_ff  <= row_sel;
      degenerate_ff <= r5_degen_ff;
      if (row_sel == lav_pkg::ROW_LAST) begin
         col0_ff     <= '0;
         col1_ff     <= '0;
         col2_ff     <= '0;
         col3_ff     <= lav_pkg::ONE_OUT;
         last_row_ff <= 1'b1;
      end else begin
         col0_ff     <= r5_col_ff[row_sel][0];
         col1_ff     <= r5_col_ff[row_sel][1];
         col2_ff     <= r5_col_ff[row_sel][2];
         col3_ff     <= r5_tr_ff[row_sel];
         last_row_ff <= 1'b0;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_row_index  = row_index_ff;
   assign rsp_col0       = col0_ff;
   assign rsp_col1       = col1_ff;
   assign rsp_col2       = col2_ff;
   assign rsp_col3       = col3_ff;
   assign rsp_last_row   = last_row_ff;
   assign rsp_degenerate = degenerate_ff;

endmodule

FILE: sv/look_at_view_matrix.sv
// Look-at view matrix: top level joining three normalisers, two cross products
// and the row output stage. Depends on lav_pkg, lav_norm, lav_cross and lav_rows.
//
// Usage
//   A request (eye, target and world up, signed Q16.16) is taken on a rising
//   edge where start is high and busy is low. The block returns the 4x4 view
//   matrix as four results, rows 0 to 3 on consecutive cycles, each marked by
//   rsp_strobe for one cycle; rsp_last_row flags row 3 and rsp_degenerate is
//   set on all four rows when a vector to normalise had zero length.
//   Busy is high after each accepted request while the hold counter runs
//   down, since each request fills the result port for its four rows. The
//   datapath is a fixed-latency pipeline: root and quotient bits take one
//   stage each, so many requests are in flight at once.
//   The receiver has no back-pressure; results must be taken as they appear.
//   Reset clears all valid bits, the row sequencer and busy; no request or
//   result survives it.
module look_at_view_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_eye_x,
   input  logic signed [31:0]  req_eye_y,
   input  logic signed [31:0]  req_eye_z,
   input  logic signed [31:0]  req_target_x,
   input  logic signed [31:0]  req_target_y,
   input  logic signed [31:0]  req_target_z,
   input  logic signed [31:0]  req_up_x,
   input  logic signed [31:0]  req_up_y,
   input  logic signed [31:0]  req_up_z,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_row_index,
   output logic signed [35:0]  rsp_col0,
   output logic signed [35:0]  rsp_col1,
   output logic signed [35:0]  rsp_col2,
   output logic signed [35:0]  rsp_col3,
   output logic                rsp_last_row,
   output logic                rsp_degenerate
);

   // Hold busy high after each accepted request while the hold counter runs down
   logic       accept;
   logic [1:0] hold_ff;
   logic [1:0] hold_in;

   assign accept = start && !busy;

   always_comb begin
      if (accept) begin
         hold_in = 2'd3;
      end else if (hold_ff != 2'd0) begin
         hold_in = hold_ff - 2'd1;
      end else begin
         hold_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 2'd0;
      end else begin
         hold_ff <= hold_in;
      end
   end

   assign busy = (hold_ff != 2'd0);

   // Register the request and form eye minus target
   logic               s0_valid_ff;
   lav_pkg::wvec_type  s0_vec_ff;
   lav_pkg::side_type  s0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_vec_ff.x        <= 64'(req_eye_x) - 64'(req_target_x);
      s0_vec_ff.y        <= 64'(req_eye_y) - 64'(req_target_y);
      s0_vec_ff.z        <= 64'(req_eye_z) - 64'(req_target_z);
      s0_side_ff.eye.x   <= req_eye_x;
      s0_side_ff.eye.y   <= req_eye_y;
      s0_side_ff.eye.z   <= req_eye_z;
      s0_side_ff.aux_a.x <= req_up_x;
      s0_side_ff.aux_a.y <= req_up_y;
      s0_side_ff.aux_a.z <= req_up_z;
      s0_side_ff.aux_b   <= '0;
      s0_side_ff.degen   <= 1'b0;
   end

   // Direction axis
   logic               n1_valid;
   lav_pkg::vec_type   n1_unit;
   logic               n1_zero;
   lav_pkg::side_type  n1_side;

   lav_norm u_norm_dir (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_valid_ff),
      .in_vec    (s0_vec_ff),
      .in_side   (s0_side_ff),
      .out_valid (n1_valid),
      .out_unit  (n1_unit),
      .out_zero  (n1_zero),
      .out_side  (n1_side)
   );

   // Up x dir
   lav_pkg::side_type  c1_side_in;
   always_comb begin
      c1_side_in.eye   = n1_side.eye;
      c1_side_in.aux_a = n1_unit;
      c1_side_in.aux_b = '0;
      c1_side_in.degen = n1_zero;
   end

   logic               c1_valid;
   lav_pkg::wvec_type  c1_vec;
   lav_pkg::side_type  c1_side;

   lav_cross u_cross_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n1_valid),
      .in_a      (n1_side.aux_a),
      .in_b      (n1_unit),
      .in_side   (c1_side_in),
      .out_valid (c1_valid),
      .out_vec   (c1_vec),
      .out_side  (c1_side)
   );

   // Right axis
   logic               n2_valid;
   lav_pkg::vec_type   n2_unit;
   logic               n2_zero;
   lav_pkg::side_type  n2_side;

   lav_norm u_norm_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid),
      .in_vec    (c1_vec),
      .in_side   (c1_side),
      .out_valid (n2_valid),
      .out_unit  (n2_unit),
      .out_zero  (n2_zero),
      .out_side  (n2_side)
   );

   // Dir x right
   lav_pkg::side_type  c2_side_in;
   always_comb begin
      c2_side_in.eye   = n2_side.eye;
      c2_side_in.aux_a = n2_side.aux_a;
      c2_side_in.aux_b = n2_unit;
      c2_side_in.degen = n2_side.degen | n2_zero;
   end

   logic               c2_valid;
   lav_pkg::wvec_type  c2_vec;
   lav_pkg::side_type  c2_side;

   lav_cross u_cross_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n2_valid),
      .in_a      (n2_side.aux_a),
      .in_b      (n2_unit),
      .in_side   (c2_side_in),
      .out_valid (c2_valid),
      .out_vec   (c2_vec),
      .out_side  (c2_side)
   );

   // Camera up axis
   logic               n3_valid;
   lav_pkg::vec_type   n3_unit;
   logic               n3_zero;
   lav_pkg::side_type  n3_side;

   lav_norm u_norm_up (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c2_valid),
      .in_vec    (c2_vec),
      .in_side   (c2_side),
      .out_valid (n3_valid),
      .out_unit  (n3_unit),
      .out_zero  (n3_zero),
      .out_side  (n3_side)
   );

   // Rows out
   lav_rows u_rows (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (n3_valid),
      .in_eye         (n3_side.eye),
      .in_right       (n3_side.aux_b),
      .in_cup         (n3_unit),
      .in_dir         (n3_side.aux_a),
      .in_degen       (n3_side.degen | n3_zero),
      .rsp_strobe     (rsp_strobe),
      .rsp_row_index  (rsp_row_index),
      .rsp_col0       (rsp_col0),
      .rsp_col1       (rsp_col1),
      .rsp_col2       (rsp_col2),
      .rsp_col3       (rsp_col3),
      .rsp_last_row   (rsp_last_row),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

FILE: tb/sv/tb_look_at_view_matrix.sv
// Testbench for the look-at view matrix unit: directed table plus random requests,
// every row checked against a behavioural predictor. Depends on lav_pkg and look_at_view_matrix.
`timescale 1ns / 1ps

module tb_look_at_view_matrix;

   localparam int LATENCY    = 233;
   localparam int WATCHDOG   = 4000;
   localparam int N_RANDOM   = 300;

   typedef struct {
      logic [1:0]         row;
      logic signed [35:0] c0, c1, c2, c3;
      logic               last, degen;
   } row_type;

   typedef struct {
      logic signed [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz;
      logic               has_row0;   // typed-in expectation for row 0
      logic signed [35:0] r0c0, r0c1, r0c2, r0c3;
      logic               degen;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [31:0] req_up_x = '0, req_up_y = '0, req_up_z = '0;
   logic rsp_strobe, rsp_last_row, rsp_degenerate;
   logic [1:0] rsp_row_index;
   logic signed [35:0] rsp_col0, rsp_col1, rsp_col2, rsp_col3;

   row_type rows_expected[$];
   int      errors = 0;
   int      idle_cycles = 0;

   always #1 clock = ~clock;

   look_at_view_matrix u_dut (.*);

   // Integer square root, floor
   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // Scale to [2^29, 2^30), take the length, divide out to Q1.30
   function automatic bit unit_vector(input longint v[3], output longint u[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         u = '{0, 0, 0};
         return 1;
      end
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << 30) + (len >> 1)) / len;
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 0;
   endfunction

   function automatic longint round_off(longint x, int sh);
      longint unsigned m;
      m = (mag(x) + (64'd1 << (sh - 1))) >> sh;
      return x < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [35:0] clamp36(longint v);
      if (v > 64'sd34359738367) return 36'sh7FFFFFFFF;
      if (v < -64'sd34359738368) return 36'sh800000000;
      return v[35:0];
   endfunction

   function automatic void cross_prod(input longint a[3], input longint b[3],
                                      output longint r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   // Build the four matrix rows for one request and queue them
   task automatic predict_view_rows(stim_type s);
      longint eye[3], upv[3], d[3], dir[3], rr[3], rgt[3], ur[3], cup[3], ax[3], dot;
      bit      dg;
      row_type r;
      eye = '{longint'(s.ex), longint'(s.ey), longint'(s.ez)};
      d   = '{eye[0] - longint'(s.tx), eye[1] - longint'(s.ty), eye[2] - longint'(s.tz)};
      upv = '{longint'(s.ux), longint'(s.uy), longint'(s.uz)};
      dg = unit_vector(d, dir);
      cross_prod(upv, dir, rr);
      dg |= unit_vector(rr, rgt);
      cross_prod(dir, rgt, ur);
      dg |= unit_vector(ur, cup);
      for (int k = 0; k < 3; k++) begin
         if (k == 0) ax = rgt;
         else if (k == 1) ax = cup;
         else ax = dir;
         dot = ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2];
         r.row = 2'(k);
         r.c0 = clamp36(round_off(ax[0], 14));
         r.c1 = clamp36(round_off(ax[1], 14));
         r.c2 = clamp36(round_off(ax[2], 14));
         r.c3 = clamp36(-round_off(dot, 30));
         r.last = 1'b0;
         r.degen = dg;
         if (k == 0 && s.has_row0) begin
            // typed-in expectation must agree with the predictor too
            if (r.c0 !== s.r0c0 || r.c1 !== s.r0c1 || r.c2 !== s.r0c2 || r.c3 !== s.r0c3
                || dg !== s.degen) begin
               $error("directed row0 table disagrees with predictor");
               errors++;
            end
            r.c0 = s.r0c0; r.c1 = s.r0c1; r.c2 = s.r0c2; r.c3 = s.r0c3; r.degen = s.degen;
         end
         rows_expected.push_back(r);
      end
      r.row = lav_pkg::ROW_LAST;
      r.c0 = 0; r.c1 = 0; r.c2 = 0; r.c3 = lav_pkg::ONE_OUT;
      r.last = 1'b1;
      r.degen = dg;
      rows_expected.push_back(r);
   endtask

   // Compare each strobed row with the oldest expectation
   always @(posedge clock) begin
      row_type e;
      if (!reset && rsp_strobe) begin
         if (rows_expected.size() == 0) begin
            $error("unexpected row %0d", rsp_row_index);
            errors++;
         end else begin
            e = rows_expected.pop_front();
            if (rsp_row_index !== e.row) begin
               $error("row_index exp %0d got %0d", e.row, rsp_row_index); errors++;
            end
            if (rsp_col0 !== e.c0) begin
               $error("col0 exp %0d got %0d", e.c0, rsp_col0); errors++;
            end
            if (rsp_col1 !== e.c1) begin
               $error("col1 exp %0d got %0d", e.c1, rsp_col1); errors++;
            end
            if (rsp_col2 !== e.c2) begin
               $error("col2 exp %0d got %0d", e.c2, rsp_col2); errors++;
            end
            if (rsp_col3 !== e.c3) begin
               $error("col3 exp %0d got %0d", e.c3, rsp_col3); errors++;
            end
            if (rsp_last_row !== e.last) begin
               $error("last_row exp %0d got %0d", e.last, rsp_last_row); errors++;
            end
            if (rsp_degenerate !== e.degen) begin
               $error("degenerate exp %0d got %0d", e.degen, rsp_degenerate); errors++;
            end
         end
      end
   end

   // Watchdog on cycles where nothing is accepted and no row is strobed
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("watchdog expired");
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_word(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
         2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return 32'($signed($urandom_range(0, 8)) - 4);
      endcase
   endfunction

   function automatic stim_type make_random();
      stim_type s;
      int mode;
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 1 : (mode < 8) ? 0 : (mode == 8) ? 2 : 3;
      s.ex = rand_word(mode); s.ey = rand_word(mode); s.ez = rand_word(mode);
      s.tx = rand_word(mode); s.ty = rand_word(mode); s.tz = rand_word(mode);
      s.ux = rand_word(mode); s.uy = rand_word(mode); s.uz = rand_word(mode);
      // occasionally force a coincident eye/target, an up parallel to the view or a zero up
      case ($urandom_range(0, 19))
         0: begin s.tx = s.ex; s.ty = s.ey; s.tz = s.ez; end
         1: begin s.ux = s.ex - s.tx; s.uy = s.ey - s.ty; s.uz = s.ez - s.tz; end
         2: begin s.ux = 0; s.uy = 0; s.uz = 0; end
         default: ;
      endcase
      s.has_row0 = 0;
      return s;
   endfunction

   // Drive one request and wait for its acceptance, with a random gap first
   task automatic send_request(stim_type s);
      int gap;
      gap = ($urandom_range(0, 9) < 7) ? 0 : ($urandom_range(0, 9) < 8) ?
            $urandom_range(1, 4) : $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_eye_x    <= s.ex; req_eye_y    <= s.ey; req_eye_z    <= s.ez;
      req_target_x <= s.tx; req_target_y <= s.ty; req_target_z <= s.tz;
      req_up_x     <= s.ux; req_up_y     <= s.uy; req_up_z     <= s.uz;
      do @(posedge clock); while (busy);
      predict_view_rows(s);
   endtask

   localparam logic signed [31:0] ONE = 32'sh10000;
   stim_type directed[$];

   initial begin
      stim_type s;
      // eye on +z looking at origin, y up: identity rotation, translation -1 on row 2
      directed.push_back('{0, 0, ONE, 0, 0, 0, 0, ONE, 0, 1, 65536, 0, 0, 0, 0});
      // eye equal to target: zero direction
      directed.push_back('{ONE, ONE, ONE, ONE, ONE, ONE, 0, ONE, 0, 1, 0, 0, 0, 0, 1});
      // up parallel to direction: zero right axis
      directed.push_back('{0, 0, ONE, 0, 0, 0, 0, 0, ONE, 1, 0, 0, 0, 0, 1});
      // zero up vector
      directed.push_back('{0, 0, ONE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1});
      // extremes of the fields
      directed.push_back('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                           32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                           32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 0,0,0,0,0});
      directed.push_back('{32'sh80000000, 0, 0, 0, 0, 0, 0, 32'sh80000000, 0, 0, 0,0,0,0,0});
      directed.push_back('{32'sh7FFFFFFF, 32'sh80000000, 1, -1, 1, -1,
                           32'shFFFFFFFF, 1, 32'shFFFFFFFF, 0, 0, 0, 0, 0, 0});
      directed.push_back('{1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{-1, -1, -1, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{32'sh55555555, 32'shAAAAAAAA, 32'sh33333333,
                           32'shCCCCCCCC, 32'sh0F0F0F0F, 32'shF0F0F0F0,
                           32'sh12345678, 32'shEDCBA987, 32'sh00FF00FF, 0,0,0,0,0,0});
      directed.push_back('{5 * ONE, 3 * ONE, -7 * ONE, ONE, -ONE, 2 * ONE,
                           0, ONE, 0, 0, 0, 0, 0, 0, 0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_request(directed[i]);
      for (int n = 0; n < N_RANDOM; n++) begin
         s = make_random();
         send_request(s);
      end
      start <= 1'b0;

      // drain
      while (rows_expected.size() != 0) @(posedge clock);
      repeat (LATENCY / 8) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
